// ===== hw/rtl/baro_pressure_temp_compensation_defines.svh =====
// assertion macros shared by the rtl files
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_DEFINES_SVH

// clocked assertion, off while in reset
`define BPC_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// same-cycle implication
`define BPC_ASSERT_IMP(lbl, ante, cons, msg) \
	`BPC_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// ===== hw/rtl/bpc_pkg.sv =====
package bpc_pkg;

	typedef struct packed {
		logic [23:0] raw_pressure;
		logic [23:0] raw_temperature;
	} sample_t;

	typedef struct packed {
		logic signed [31:0] pressure_comp;
		logic signed [15:0] temperature_comp;
		logic               saturated;
	} result_t;

	typedef struct packed {
		logic signed [11:0] c0;
		logic signed [11:0] c1;
		logic signed [19:0] c00;
		logic signed [19:0] c10;
		logic signed [15:0] c01;
		logic signed [15:0] c11;
		logic signed [15:0] c20;
		logic signed [15:0] c21;
		logic signed [15:0] c30;
	} coef_t;

	typedef enum logic [2:0] {
		REG_CAL0 = 3'd0,
		REG_CAL1 = 3'd1,
		REG_CAL2 = 3'd2,
		REG_POSR = 3'd3,
		REG_TOSR = 3'd4
	} reg_idx_t;

	localparam int CFG_W = 48;
	localparam int IDX_W = 3;
	localparam int OSR_W = 3;
	localparam logic [OSR_W-1:0] OSR_RESET = 3'd6;

	// scale factor k = div * 2^(24 - lsh)
	localparam logic [7:0] SCALE_DIV [8] = '{
		8'd1, 8'd3, 8'd7, 8'd15, 8'd31, 8'd63, 8'd127, 8'd255
	};
	localparam logic [3:0] SCALE_LSH [8] = '{
		4'd5, 4'd5, 4'd5, 4'd5, 4'd11, 4'd11, 4'd11, 4'd11
	};

	localparam int DIV_W       = 35;
	localparam int DIV_STEP    = 7;
	localparam int DIV_STAGES  = DIV_W / DIV_STEP;
	localparam int PSC_W       = 30;
	localparam int POLY_STAGES = 13;

endpackage

// ===== hw/rtl/bpc_div.sv =====
`include "baro_pressure_temp_compensation_defines.svh"

module bpc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic [23:0]                raw,
	input  logic [bpc_pkg::OSR_W-1:0]  osr,
	output logic                       out_valid,
	output logic [bpc_pkg::PSC_W-1:0]  quo,
	output logic                       neg
);

	localparam int NS = bpc_pkg::DIV_STAGES;
	localparam int DW = bpc_pkg::DIV_W;

	logic [DW-1:0] work_s [0:NS];
	logic [7:0]    rem_s  [0:NS];
	logic [7:0]    den_s  [0:NS];
	logic          neg_s  [0:NS];
	logic          vld_s  [0:NS];

	logic [23:0]   mag;
	logic [DW-1:0] num;
	logic [DW-1:0] w_nx   [0:NS-1];
	logic [7:0]    r_nx   [0:NS-1];

	// rounded numerator already shifted down by the power-of-two part of k
	always_comb begin
		mag = raw[23] ? -raw : raw;
		num = (DW'(mag) << bpc_pkg::SCALE_LSH[osr]) + DW'(bpc_pkg::SCALE_DIV[osr] >> 1);
	end

	// restoring division, a group of quotient bits per stage
	always_comb begin
		logic [8:0]    t;
		logic [DW-1:0] w;
		logic [7:0]    r;
		for (int g = 0; g < NS; g++) begin
			w = work_s[g];
			r = rem_s[g];
			for (int k = 0; k < bpc_pkg::DIV_STEP; k++) begin
				t = {r, w[DW-1]};
				w = {w[DW-2:0], 1'b0};
				if (t >= {1'b0, den_s[g]}) begin
					r    = 8'(t - {1'b0, den_s[g]});
					w[0] = 1'b1;
				end else begin
					r = t[7:0];
				end
			end
			w_nx[g] = w;
			r_nx[g] = r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int g = 0; g <= NS; g++) vld_s[g] <= 1'b0;
		end else begin
			vld_s[0] <= in_valid;
			for (int g = 0; g < NS; g++) vld_s[g+1] <= vld_s[g];
		end
	end

	always_ff @(posedge clk) begin
		work_s[0] <= num;
		rem_s[0]  <= '0;
		den_s[0]  <= bpc_pkg::SCALE_DIV[osr];
		neg_s[0]  <= raw[23];
		for (int g = 0; g < NS; g++) begin
			work_s[g+1] <= w_nx[g];
			rem_s[g+1]  <= r_nx[g];
			den_s[g+1]  <= den_s[g];
			neg_s[g+1]  <= neg_s[g];
		end
	end

	assign out_valid = vld_s[NS];
	assign quo       = work_s[NS][bpc_pkg::PSC_W-1:0];
	assign neg       = neg_s[NS];

	`BPC_ASSERT_IMP(a_quo_fits, vld_s[NS], work_s[NS][DW-1:bpc_pkg::PSC_W] == '0, "quotient overflow")
	`BPC_ASSERT_IMP(a_rem_lt_den, vld_s[NS], rem_s[NS] < den_s[NS], "remainder not below divisor")

endmodule

// ===== hw/rtl/bpc_poly.sv =====
`include "baro_pressure_temp_compensation_defines.svh"

module bpc_poly (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	input  logic [bpc_pkg::PSC_W-1:0] pm,
	input  logic                      pneg,
	input  logic [bpc_pkg::PSC_W-1:0] tm,
	input  logic                      tneg,
	input  bpc_pkg::coef_t            coef,
	output logic                      out_valid,
	output bpc_pkg::result_t          result
);

	localparam int NS = bpc_pkg::POLY_STAGES;
	localparam int QW = bpc_pkg::PSC_W;

	logic              vld_s [1:NS];
	logic [QW-1:0]     pm_s   [1:8];
	logic              pneg_s [1:8];
	logic signed [47:0] base_s [3:7];
	logic [16:0]       tres_s [5:12];

	logic signed [QW:0] psc_s1, tsc_s1;
	logic [QW-1:0]      tm_s1;
	logic               tneg_s1;

	logic signed [46:0] c30p_s2, c21p_s2, c01t_s2;
	logic signed [42:0] c1t_s2;
	logic [59:0]        tpm_s2;
	logic               ttn_s2;

	logic signed [47:0] s1v_s3, s3v_s3;
	logic signed [44:0] tq_s3;
	logic [35:0]        ttm_s3;
	logic               ttn_s3;

	logic [47:0]        s1m_s4, s3m_s4;
	logic [44:0]        tqm_s4;
	logic [35:0]        ttm_s4;
	logic               s1n_s4, s3n_s4, tqn_s4, ttn_s4;

	logic [53:0]        pa_lo_s5, pa_hi_s5;
	logic [59:0]        pb_lo_s5, pb_hi_s5;
	logic               n1_s5, qbn_s5;

	logic [53:0]        r1m_s6;
	logic [59:0]        qbm_s6;
	logic               n1_s6, qbn_s6;

	logic signed [55:0] qua2_s7;
	logic signed [60:0] qua3_s7;

	logic [55:0]        qua2m_s8;
	logic               qua2n_s8;
	logic signed [61:0] base2_s8;

	logic [57:0]        pc_lo_s9, pc_hi_s9;
	logic               n2_s9;
	logic signed [61:0] base2_s9;

	logic [61:0]        r2m_s10;
	logic               n2_s10;
	logic signed [61:0] base2_s10;

	logic signed [63:0] pq_s11;
	logic [63:0]        pmag_s12;
	logic               pn_s12;

	bpc_pkg::result_t   res_s13;

	logic [44:0] t_sum;
	logic [28:0] t_rnd;
	logic [15:0] t_val;
	logic        t_sat;
	logic [63:0] p_sum;
	logic [45:0] p_rnd;
	logic [31:0] p_val;
	logic        p_sat;

	// temperature: round to 1/256 degC and clip
	always_comb begin
		t_sum = tqm_s4 + 45'd32768;
		t_rnd = t_sum[44:16];
		t_sat = 1'b0;
		if (!tqn_s4) begin
			if (t_rnd > 29'd32767) begin
				t_val = 16'h7fff;
				t_sat = 1'b1;
			end else begin
				t_val = t_rnd[15:0];
			end
		end else begin
			if (t_rnd > 29'd32768) begin
				t_val = 16'h8000;
				t_sat = 1'b1;
			end else begin
				t_val = -t_rnd[15:0];
			end
		end
	end

	// pressure: round to 1/64 Pa and clip
	always_comb begin
		p_sum = pmag_s12 + 64'd131072;
		p_rnd = p_sum[63:18];
		p_sat = 1'b0;
		if (!pn_s12) begin
			if (p_rnd > 46'h7fffffff) begin
				p_val = 32'h7fffffff;
				p_sat = 1'b1;
			end else begin
				p_val = p_rnd[31:0];
			end
		end else begin
			if (p_rnd > 46'h80000000) begin
				p_val = 32'h80000000;
				p_sat = 1'b1;
			end else begin
				p_val = -p_rnd[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= NS; k++) vld_s[k] <= 1'b0;
		end else begin
			vld_s[1] <= in_valid;
			for (int k = 2; k <= NS; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		// signed scaled values
		psc_s1    <= pneg ? -$signed({1'b0, pm}) : $signed({1'b0, pm});
		tsc_s1    <= tneg ? -$signed({1'b0, tm}) : $signed({1'b0, tm});
		tm_s1     <= tm;
		tneg_s1   <= tneg;
		pm_s[1]   <= pm;
		pneg_s[1] <= pneg;
		for (int k = 2; k <= 8; k++) begin
			pm_s[k]   <= pm_s[k-1];
			pneg_s[k] <= pneg_s[k-1];
		end

		// coefficient products and tsc*psc
		c30p_s2 <= coef.c30 * psc_s1;
		c21p_s2 <= coef.c21 * psc_s1;
		c01t_s2 <= coef.c01 * tsc_s1;
		c1t_s2  <= coef.c1 * tsc_s1;
		tpm_s2  <= pm_s[1] * tm_s1;
		ttn_s2  <= pneg_s[1] ^ tneg_s1;

		// inner sums
		s1v_s3    <= (48'(coef.c20) <<< 24) + 48'(c30p_s2);
		s3v_s3    <= (48'(coef.c11) <<< 24) + 48'(c21p_s2);
		tq_s3     <= (45'(coef.c0) <<< 23) + 45'(c1t_s2);
		base_s[3] <= (48'(coef.c00) <<< 24) + 48'(c01t_s2);
		ttm_s3    <= 36'((tpm_s2 + 60'd8388608) >> 24);
		ttn_s3    <= ttn_s2;
		for (int k = 4; k <= 7; k++) base_s[k] <= base_s[k-1];

		// magnitudes
		s1m_s4 <= s1v_s3[47] ? -s1v_s3 : s1v_s3;
		s1n_s4 <= s1v_s3[47];
		s3m_s4 <= s3v_s3[47] ? -s3v_s3 : s3v_s3;
		s3n_s4 <= s3v_s3[47];
		tqm_s4 <= tq_s3[44] ? -tq_s3 : tq_s3;
		tqn_s4 <= tq_s3[44];
		ttm_s4 <= ttm_s3;
		ttn_s4 <= ttn_s3;

		// split products psc*s1 and tt*s3
		pa_lo_s5  <= pm_s[4] * s1m_s4[23:0];
		pa_hi_s5  <= pm_s[4] * s1m_s4[47:24];
		pb_lo_s5  <= ttm_s4 * s3m_s4[23:0];
		pb_hi_s5  <= ttm_s4 * s3m_s4[47:24];
		n1_s5     <= pneg_s[4] ^ s1n_s4;
		qbn_s5    <= ttn_s4 ^ s3n_s4;
		tres_s[5] <= {t_sat, t_val};
		for (int k = 6; k <= 12; k++) tres_s[k] <= tres_s[k-1];

		// combine and round to q24
		r1m_s6 <= 54'(({pa_hi_s5, 24'd0} + 78'(pa_lo_s5) + 78'd8388608) >> 24);
		qbm_s6 <= 60'(({pb_hi_s5, 24'd0} + 84'(pb_lo_s5) + 84'd8388608) >> 24);
		n1_s6  <= n1_s5;
		qbn_s6 <= qbn_s5;

		qua2_s7 <= n1_s6 ? (56'(coef.c10) <<< 24) - 56'(r1m_s6)
		                 : (56'(coef.c10) <<< 24) + 56'(r1m_s6);
		qua3_s7 <= qbn_s6 ? -61'(qbm_s6) : 61'(qbm_s6);

		qua2m_s8 <= qua2_s7[55] ? -qua2_s7 : qua2_s7;
		qua2n_s8 <= qua2_s7[55];
		base2_s8 <= 62'(base_s[7]) + 62'(qua3_s7);

		// split product psc*qua2
		pc_lo_s9 <= pm_s[8] * qua2m_s8[27:0];
		pc_hi_s9 <= pm_s[8] * qua2m_s8[55:28];
		n2_s9    <= pneg_s[8] ^ qua2n_s8;
		base2_s9 <= base2_s8;

		r2m_s10   <= 62'(({pc_hi_s9, 28'd0} + 86'(pc_lo_s9) + 86'd8388608) >> 24);
		n2_s10    <= n2_s9;
		base2_s10 <= base2_s9;

		pq_s11 <= n2_s10 ? 64'(base2_s10) - 64'(r2m_s10) : 64'(base2_s10) + 64'(r2m_s10);

		pmag_s12 <= pq_s11[63] ? -pq_s11 : pq_s11;
		pn_s12   <= pq_s11[63];

		res_s13.pressure_comp    <= p_val;
		res_s13.temperature_comp <= tres_s[12][15:0];
		res_s13.saturated        <= p_sat | tres_s[12][16];
	end

	assign out_valid = vld_s[NS];
	assign result    = res_s13;

	`BPC_ASSERT_IMP(a_qua2_range, vld_s[8], qua2m_s8[55:50] == '0, "pressure term out of range")

endmodule

// ===== hw/rtl/baro_pressure_temp_compensation.sv =====
// Barometric pressure and temperature compensator.
// Input channel: a transaction is taken at a rising edge with start high and busy
// low. busy never rises, so a new raw sample pair may be offered every cycle.
// Output channel: done is high for one cycle while result holds the compensated
// pressure (1/64 Pa), temperature (1/256 degC) and the clip flag; the receiver
// cannot hold results off and must take each one in that cycle.
// Datapath: each sample pair passes the two scale dividers side by side, then the
// polynomial pipeline, whose last register drives done and result.
// Throughput: one transaction per cycle, set by the fully pipelined dividers
// (7 quotient bits per stage) and the split multiplier stages.
// Configuration: cfg_we writes cfg_data to register cfg_index at a rising edge;
// indexes above the register list are dropped. Write only while no transaction
// is in flight.
// Reset: arst_n clears the pipeline valid bits, the calibration words to zero
// and both oversampling codes to 6; results in flight are dropped.
`include "baro_pressure_temp_compensation_defines.svh"

module baro_pressure_temp_compensation (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	output logic                      busy,
	input  bpc_pkg::sample_t          sample,
	output logic                      done,
	output bpc_pkg::result_t          result,
	input  logic                      cfg_we,
	input  logic [bpc_pkg::IDX_W-1:0] cfg_index,
	input  logic [bpc_pkg::CFG_W-1:0] cfg_data
);

	localparam int LATENCY = bpc_pkg::DIV_STAGES + bpc_pkg::POLY_STAGES + 1;

	logic [bpc_pkg::CFG_W-1:0] cal0_q, cal1_q, cal2_q;
	logic [bpc_pkg::OSR_W-1:0] posr_q, tosr_q;
	bpc_pkg::coef_t            coef;
	logic                      accept;
	logic                      vld_p, vld_t;
	logic [bpc_pkg::PSC_W-1:0] pm, tm;
	logic                      pneg, tneg;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cal0_q <= '0;
			cal1_q <= '0;
			cal2_q <= '0;
			posr_q <= bpc_pkg::OSR_RESET;
			tosr_q <= bpc_pkg::OSR_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				bpc_pkg::REG_CAL0: cal0_q <= cfg_data;
				bpc_pkg::REG_CAL1: cal1_q <= cfg_data;
				bpc_pkg::REG_CAL2: cal2_q <= cfg_data;
				bpc_pkg::REG_POSR: posr_q <= cfg_data[bpc_pkg::OSR_W-1:0];
				bpc_pkg::REG_TOSR: tosr_q <= cfg_data[bpc_pkg::OSR_W-1:0];
				default: ;
			endcase
		end
	end

	// coefficient unpack, calibration bytes big-endian
	always_comb begin
		coef.c0  = cal0_q[47:36];
		coef.c1  = cal0_q[35:24];
		coef.c00 = cal0_q[23:4];
		coef.c10 = {cal0_q[3:0], cal1_q[47:32]};
		coef.c01 = cal1_q[31:16];
		coef.c11 = cal1_q[15:0];
		coef.c20 = cal2_q[47:32];
		coef.c21 = cal2_q[31:16];
		coef.c30 = cal2_q[15:0];
	end

	assign busy   = 1'b0;
	assign accept = start & ~busy;

	bpc_div u_div_p (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.raw       (sample.raw_pressure),
		.osr       (posr_q),
		.out_valid (vld_p),
		.quo       (pm),
		.neg       (pneg)
	);

	bpc_div u_div_t (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (accept),
		.raw       (sample.raw_temperature),
		.osr       (tosr_q),
		.out_valid (vld_t),
		.quo       (tm),
		.neg       (tneg)
	);

	bpc_poly u_poly (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld_p & vld_t),
		.pm        (pm),
		.pneg      (pneg),
		.tm        (tm),
		.tneg      (tneg),
		.coef      (coef),
		.out_valid (done),
		.result    (result)
	);

	`BPC_ASSERT(a_done_latency, done |-> $past(start && !busy, LATENCY), "result without transaction")
	`BPC_ASSERT_IMP(a_div_align, vld_p || vld_t, vld_p && vld_t, "divider outputs out of step")

endmodule

// ===== tb/sv/baro_pressure_temp_compensation_tb.sv =====
`timescale 1ns / 1ps

module baro_pressure_temp_compensation_tb;

	localparam int LATENCY = 19;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	bpc_pkg::sample_t sample;
	logic done;
	bpc_pkg::result_t result;
	logic cfg_we;
	logic [bpc_pkg::IDX_W-1:0] cfg_index;
	logic [bpc_pkg::CFG_W-1:0] cfg_data;

	baro_pressure_temp_compensation dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .sample(sample),
		.done(done), .result(result), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	logic [47:0] cal_w [3];
	logic [2:0] posr, tosr;
	bpc_pkg::result_t comp_q [$];
	int errors = 0;
	int idle_pct = 0;

	typedef struct {
		logic [23:0] rp;
		logic [23:0] rt;
		bit known;
		bpc_pkg::result_t res;
	} vec_t;

	function automatic longint sx(longint v, int w);
		longint m;
		m = (longint'(1) << w) - 1;
		v = v & m;
		if (v[w-1]) return v - (longint'(1) << w);
		return v;
	endfunction

	function automatic longint osr_scale(logic [2:0] c);
		case (c)
			3'd0: return 524288;
			3'd1: return 1572864;
			3'd2: return 3670016;
			3'd3: return 7864320;
			3'd4: return 253952;
			3'd5: return 516096;
			3'd6: return 1040384;
			default: return 2088960;
		endcase
	endfunction

	function automatic longint to_q24(longint raw, longint k);
		longint m;
		m = raw < 0 ? -raw : raw;
		m = ((m <<< 24) + k / 2) / k;
		return raw < 0 ? -m : m;
	endfunction

	function automatic longint qmul(longint a, longint b);
		logic [127:0] p;
		logic [127:0] ua, ub;
		longint r;
		ua = a < 0 ? -a : a;
		ub = b < 0 ? -b : b;
		p = ua * ub + (128'd1 << 23);
		p = p >> 24;
		if (p >= (128'd1 << 62)) r = longint'(1) <<< 62;
		else r = longint'(p[63:0]);
		return ((a < 0) != (b < 0)) ? -r : r;
	endfunction

	function automatic longint rnd_shift(longint v, int s);
		longint m;
		m = v < 0 ? -v : v;
		m = (m + (longint'(1) << (s - 1))) >>> s;
		return v < 0 ? -m : m;
	endfunction

	function automatic bpc_pkg::result_t compensate(logic [23:0] rp, logic [23:0] rt);
		logic [143:0] cb;
		longint c0, c1, c00, c10, c01, c11, c20, c21, c30, one;
		longint psc, tsc, tq, tout, s1, qua2, s3, qua3, pq, pout;
		bpc_pkg::result_t r;
		cb = {cal_w[0], cal_w[1], cal_w[2]};
		c0 = sx(cb[143:132], 12);
		c1 = sx(cb[131:120], 12);
		c00 = sx(cb[119:100], 20);
		c10 = sx(cb[99:80], 20);
		c01 = sx(cb[79:64], 16);
		c11 = sx(cb[63:48], 16);
		c20 = sx(cb[47:32], 16);
		c21 = sx(cb[31:16], 16);
		c30 = sx(cb[15:0], 16);
		one = longint'(1) << 24;
		psc = to_q24(sx(rp, 24), osr_scale(posr));
		tsc = to_q24(sx(rt, 24), osr_scale(tosr));
		tq = c0 * (one / 2) + c1 * tsc;
		tout = rnd_shift(tq, 16);
		s1 = c20 * one + c30 * psc;
		qua2 = c10 * one + qmul(psc, s1);
		s3 = c11 * one + c21 * psc;
		qua3 = qmul(qmul(tsc, psc), s3);
		pq = c00 * one + qmul(psc, qua2) + c01 * tsc + qua3;
		pout = rnd_shift(pq, 18);
		r.saturated = 1'b0;
		if (tout > 32767) begin tout = 32767; r.saturated = 1'b1; end
		if (tout < -32768) begin tout = -32768; r.saturated = 1'b1; end
		if (pout > 64'sd2147483647) begin pout = 64'sd2147483647; r.saturated = 1'b1; end
		if (pout < -64'sd2147483648) begin pout = -64'sd2147483648; r.saturated = 1'b1; end
		r.pressure_comp = pout[31:0];
		r.temperature_comp = tout[15:0];
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("CHECK FAILED");
		$finish;
	end

	always @(posedge clk) begin
		if (done) begin
			if (comp_q.size() == 0) begin
				$display("%0t: unexpected transaction, expected none actual %h", $time,
					result);
				errors++;
			end else begin
				bpc_pkg::result_t e;
				e = comp_q.pop_front();
				if (result.pressure_comp !== e.pressure_comp)
					$display("%0t: pressure expected %0d actual %0d", $time,
						e.pressure_comp, result.pressure_comp);
				if (result.temperature_comp !== e.temperature_comp)
					$display("%0t: temperature expected %0d actual %0d", $time,
						e.temperature_comp, result.temperature_comp);
				if (result.saturated !== e.saturated)
					$display("%0t: saturated expected %0b actual %0b", $time,
						e.saturated, result.saturated);
				if (result !== e) errors++;
			end
		end
	end

	task automatic write_reg(logic [bpc_pkg::IDX_W-1:0] idx, logic [bpc_pkg::CFG_W-1:0] d);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			bpc_pkg::REG_CAL0: cal_w[0] = d;
			bpc_pkg::REG_CAL1: cal_w[1] = d;
			bpc_pkg::REG_CAL2: cal_w[2] = d;
			bpc_pkg::REG_POSR: posr = d[2:0];
			bpc_pkg::REG_TOSR: tosr = d[2:0];
			default: ;
		endcase
	endtask

	task automatic drain();
		int n;
		n = 0;
		start <= 1'b0;
		while (comp_q.size() != 0 && n < 10000) begin
			@(posedge clk);
			n++;
		end
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic send_sample(logic [23:0] rp, logic [23:0] rt, bit known,
		bpc_pkg::result_t kr);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		sample <= '{raw_pressure: rp, raw_temperature: rt};
		@(posedge clk);
		while (busy) @(posedge clk);
		comp_q.push_back(known ? kr : compensate(rp, rt));
	endtask

	vec_t dir_tab [$];

	task automatic add_vec(logic [23:0] rp, logic [23:0] rt, bit known, bpc_pkg::result_t r);
		vec_t v;
		v.rp = rp;
		v.rt = rt;
		v.known = known;
		v.res = r;
		dir_tab.push_back(v);
	endtask

	initial begin
		bpc_pkg::result_t zr;
		int plen;
		zr = '0;
		arst_n = 1'b0;
		start = 1'b0;
		sample = '0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		cal_w[0] = '0;
		cal_w[1] = '0;
		cal_w[2] = '0;
		posr = bpc_pkg::OSR_RESET;
		tosr = bpc_pkg::OSR_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero calibration after reset
		add_vec(24'h000000, 24'h000000, 1, zr);
		add_vec(24'h7fffff, 24'h800000, 1, zr);
		add_vec(24'h800000, 24'h7fffff, 1, zr);
		add_vec(24'hffffff, 24'hffffff, 1, zr);
		foreach (dir_tab[i]) send_sample(dir_tab[i].rp, dir_tab[i].rt, dir_tab[i].known,
			dir_tab[i].res);
		drain();

		// extremes of calibration and oversampling
		write_reg(bpc_pkg::REG_CAL0, 48'hffffffffffff);
		write_reg(bpc_pkg::REG_CAL1, 48'h7fff7fff7fff);
		write_reg(bpc_pkg::REG_CAL2, 48'h800080008000);
		write_reg(bpc_pkg::REG_POSR, 3'd0);
		write_reg(bpc_pkg::REG_TOSR, 3'd7);
		write_reg(3'd7, 48'h123456789abc);
		dir_tab.delete();
		add_vec(24'h7fffff, 24'h7fffff, 0, zr);
		add_vec(24'h800000, 24'h800000, 0, zr);
		add_vec(24'h000001, 24'hffffff, 0, zr);
		add_vec(24'h555555, 24'haaaaaa, 0, zr);
		foreach (dir_tab[i]) send_sample(dir_tab[i].rp, dir_tab[i].rt, 0, zr);
		drain();
		write_reg(bpc_pkg::REG_CAL0, 48'h7ff8007ffff8);
		write_reg(bpc_pkg::REG_CAL2, 48'h7fff7fff7fff);
		write_reg(bpc_pkg::REG_POSR, 3'd4);
		write_reg(bpc_pkg::REG_TOSR, 3'd0);
		foreach (dir_tab[i]) send_sample(dir_tab[i].rp, dir_tab[i].rt, 0, zr);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			write_reg(bpc_pkg::REG_CAL0, 48'({$urandom, $urandom}));
			write_reg(bpc_pkg::REG_CAL1, 48'({$urandom, $urandom}));
			write_reg(bpc_pkg::REG_CAL2, 48'({$urandom, $urandom}));
			write_reg(bpc_pkg::REG_POSR, ph[2:0]);
			write_reg(bpc_pkg::REG_TOSR, 3'(7 - ph));
			case (ph % 4)
				0: idle_pct = 0;
				1: idle_pct = 54;
				2: idle_pct = 0;
				default: idle_pct = 22;
			endcase
			plen = 140;
			for (int k = 0; k < plen; k++) begin
				logic [23:0] rp, rt;
				rp = 24'($urandom);
				rt = 24'($urandom);
				if ($urandom_range(9) == 0) rp = $urandom_range(1) ? 24'h7fffff : 24'h800000;
				if ($urandom_range(9) == 0) rt = $urandom_range(1) ? 24'h7fffff : 24'h800000;
				send_sample(rp, rt, 0, zr);
			end
			drain();
		end

		if (comp_q.size() != 0) errors++;
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end
endmodule
